// ===== hdl/tz_transition_offset_lookup_core_defines.svh =====
// Assertion helpers of the lookup core engine.
`ifndef TZ_TRANSITION_OFFSET_LOOKUP_CORE_DEFINES_SVH
`define TZ_TRANSITION_OFFSET_LOOKUP_CORE_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define TOL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TOL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tol_pkg
// Types, codes and helpers of the time-zone transition lookup core.
// ----------------------------------------------------------------------------
package tol_pkg;

  localparam int DefMaxTransitions = 256;
  localparam int DefMaxTypes       = 256;

  localparam int TimeW = 64;
  localparam int OffW  = 18;
  localparam int AbbW  = 8;
  localparam int TyW   = 8;
  localparam int OpW   = 3;
  localparam int StW   = 2;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR   = 3'd0,
    OP_WR_TYPE = 3'd1,
    OP_APPEND  = 3'd2,
    OP_UTC_Q   = 3'd3,
    OP_LOC_Q   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    K_NOP, K_CLEAR, K_WR_TYPE, K_APPEND, K_UTC_Q, K_LOC_Q
  } kind_t;

  typedef enum logic [StW-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_TYPES = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_APP, S_FIRST, S_SRCH, S_SRCH_CMP, S_PICK, S_LOC_I, S_LOC_J,
    S_LOC_OFF1, S_LOC_JM1, S_LOC_OFF2, S_TYPE_RD, S_TYPE_WAIT
  } state_t;

  typedef struct packed {
    kind_t                    kind;
    logic [TyW-1:0]           type_index;
    logic signed [OffW-1:0]   offset_seconds;
    logic                     dst_flag;
    logic [AbbW-1:0]          abbrev_index;
    logic signed [TimeW-1:0]  time_value;
    logic                     after_transition;
  } cmd_t;

  typedef struct packed {
    logic signed [OffW-1:0] offset;
    logic                   dst;
    logic [AbbW-1:0]        abbrev;
  } type_ent_t;

  typedef struct packed {
    logic signed [TimeW-1:0] utc;
    logic signed [TimeW-1:0] loc;
    logic [TyW-1:0]          ty;
  } trans_ent_t;

  // Queue handshake between the front and the engine.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  function automatic logic signed [TimeW-1:0] off_ext(input logic signed [OffW-1:0] o);
    return TimeW'(o);
  endfunction

endpackage

// ===== hdl/tol_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tol_in_if / tol_out_if
// Valid/ready channels of the lookup core.
// ----------------------------------------------------------------------------
interface tol_in_if import tol_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          opcode;
  logic [TyW-1:0]          type_index;
  logic signed [OffW-1:0]  offset_seconds;
  logic                    dst_flag;
  logic [AbbW-1:0]         abbrev_index;
  logic signed [TimeW-1:0] time_value;
  logic                    after_transition;

  modport source (output valid, opcode, type_index, offset_seconds, dst_flag,
                  abbrev_index, time_value, after_transition, input ready);
  modport sink (input valid, opcode, type_index, offset_seconds, dst_flag,
                abbrev_index, time_value, after_transition, output ready);
endinterface

interface tol_out_if import tol_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TimeW-1:0] result_seconds;
  logic signed [OffW-1:0]  chosen_offset;
  logic                    chosen_dst;
  logic [AbbW-1:0]         chosen_abbrev;
  logic [StW-1:0]          status;

  modport source (output valid, result_seconds, chosen_offset, chosen_dst,
                  chosen_abbrev, status, input ready);
  modport sink (input valid, result_seconds, chosen_offset, chosen_dst,
                chosen_abbrev, status, output ready);
endinterface

// ===== hdl/tol_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tol_front
// Accepts input beats, decodes the opcode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tol_front import tol_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tol_in_if.sink     in_ch,
  output q_head_t    q_head,
  input  logic       q_pop
);

  cmd_t        q_mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  kind_t       kind;
  cmd_t        cmd_in;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;

  always_comb begin
    case (in_ch.opcode)
      OP_CLEAR:   kind = K_CLEAR;
      OP_WR_TYPE: kind = K_WR_TYPE;
      OP_APPEND:  kind = K_APPEND;
      OP_UTC_Q:   kind = K_UTC_Q;
      OP_LOC_Q:   kind = K_LOC_Q;
      default:    kind = K_NOP;
    endcase
    cmd_in.kind             = kind;
    cmd_in.type_index       = in_ch.type_index;
    cmd_in.offset_seconds   = in_ch.offset_seconds;
    cmd_in.dst_flag         = in_ch.dst_flag;
    cmd_in.abbrev_index     = in_ch.abbrev_index;
    cmd_in.time_value       = in_ch.time_value;
    cmd_in.after_transition = in_ch.after_transition;
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hdl/tol_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tol_engine
// Holds the type and transition tables and runs one command at a time:
// table updates, binary search and the gap/overlap rule for local times.
// ----------------------------------------------------------------------------
`include "tz_transition_offset_lookup_core_defines.svh"
module tol_engine import tol_pkg::*; #(
  parameter int MaxTransitions = DefMaxTransitions,
  parameter int MaxTypes       = DefMaxTypes
) (
  input  logic     clk,
  input  logic     rst_n,
  input  q_head_t  q_head,
  output logic     q_pop,
  tol_out_if.source out_ch
);

  localparam int TAW  = (MaxTransitions > 1) ? $clog2(MaxTransitions) : 1;
  localparam int TCW  = $clog2(MaxTransitions + 1);
  localparam int TYAW = (MaxTypes > 1) ? $clog2(MaxTypes) : 1;
  localparam int TYCW = $clog2(MaxTypes + 1);

  type_ent_t  type_mem [MaxTypes];
  trans_ent_t trans_mem [MaxTransitions];
  type_ent_t  type_rd_r;
  trans_ent_t trans_rd_r;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic [TCW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, trans_count_r, trans_count_nxt;
  logic [TAW-1:0]  mid_r, mid_nxt;
  logic [TYCW-1:0] type_count_r, type_count_nxt;
  logic signed [TimeW-1:0] utc_i_r, utc_i_nxt, utc_j_r, utc_j_nxt;
  logic [TyW-1:0]  type_i_r, type_i_nxt, type_j_r, type_j_nxt, ty_r, ty_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [TimeW-1:0] res_sec_r, res_sec_nxt;
  logic signed [OffW-1:0]  res_off_r, res_off_nxt;
  logic                    res_dst_r, res_dst_nxt;
  logic [AbbW-1:0]         res_abb_r, res_abb_nxt;
  status_t                 res_st_r, res_st_nxt;

  logic [TYAW-1:0] type_raddr;
  logic [TAW-1:0]  trans_raddr;
  logic            type_we, trans_we;
  type_ent_t       type_wdata;
  trans_ent_t      trans_wdata;

  logic signed [TimeW-1:0] key, prior, off64;
  logic [TCW:0]    mid_sum;
  logic [TCW-1:0]  lo_m1, lo_m2;
  logic [8:0]      idx_p1;
  cmd_t            fc;

  always_ff @(posedge clk) begin
    if (type_we) type_mem[type_raddr] <= type_wdata;
    type_rd_r <= type_mem[type_raddr];
  end

  always_ff @(posedge clk) begin
    if (trans_we) trans_mem[trans_count_r[TAW-1:0]] <= trans_wdata;
    trans_rd_r <= trans_mem[trans_raddr];
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    trans_count_nxt = trans_count_r;
    type_count_nxt  = type_count_r;
    utc_i_nxt       = utc_i_r;
    utc_j_nxt       = utc_j_r;
    type_i_nxt      = type_i_r;
    type_j_nxt      = type_j_r;
    ty_nxt          = ty_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    res_sec_nxt     = res_sec_r;
    res_off_nxt     = res_off_r;
    res_dst_nxt     = res_dst_r;
    res_abb_nxt     = res_abb_r;
    res_st_nxt      = res_st_r;
    q_pop           = 1'b0;
    type_raddr      = ty_r[TYAW-1:0];
    trans_raddr     = mid_r;
    type_we         = 1'b0;
    trans_we        = 1'b0;
    fc              = q_head.cmd;
    type_wdata      = '{offset: fc.offset_seconds, dst: fc.dst_flag, abbrev: fc.abbrev_index};
    off64           = off_ext(type_rd_r.offset);
    trans_wdata     = '{utc: cmd_r.time_value, loc: cmd_r.time_value + off64,
                        ty: cmd_r.type_index};
    key             = (cmd_r.kind == K_UTC_Q) ? trans_rd_r.utc : trans_rd_r.loc;
    mid_sum         = {1'b0, lo_r} + {1'b0, hi_r};
    lo_m1           = lo_r - TCW'(1);
    lo_m2           = lo_r - TCW'(2);
    idx_p1          = {1'b0, fc.type_index} + 9'd1;
    prior           = '0;

    case (state_r)
      S_IDLE: begin
        if (q_head.valid && !out_valid_r) begin
          q_pop         = 1'b1;
          cmd_nxt       = fc;
          out_valid_nxt = 1'b1;
          res_sec_nxt   = '0;
          res_off_nxt   = '0;
          res_dst_nxt   = 1'b0;
          res_abb_nxt   = '0;
          res_st_nxt    = ST_OK;
          case (fc.kind)
            K_CLEAR: begin
              type_count_nxt  = '0;
              trans_count_nxt = '0;
            end
            K_WR_TYPE: begin
              if ({1'b0, fc.type_index} >= 9'(MaxTypes)) begin
                res_st_nxt = ST_BAD_TYPE;
              end else begin
                type_raddr  = fc.type_index[TYAW-1:0];
                type_we     = 1'b1;
                res_off_nxt = fc.offset_seconds;
                res_dst_nxt = fc.dst_flag;
                res_abb_nxt = fc.abbrev_index;
                if (9'(type_count_r) < idx_p1) type_count_nxt = TYCW'(idx_p1);
              end
            end
            K_APPEND: begin
              if ({1'b0, fc.type_index} >= 9'(type_count_r)) begin
                res_st_nxt = ST_BAD_TYPE;
              end else if (trans_count_r == TCW'(MaxTransitions)) begin
                res_st_nxt = ST_FULL;
              end else begin
                out_valid_nxt = 1'b0;
                type_raddr    = fc.type_index[TYAW-1:0];
                state_nxt     = S_APP;
              end
            end
            K_UTC_Q, K_LOC_Q: begin
              if (type_count_r == '0) begin
                res_st_nxt = ST_NO_TYPES;
              end else if (trans_count_r == '0) begin
                out_valid_nxt = 1'b0;
                ty_nxt        = '0;
                state_nxt     = S_TYPE_RD;
              end else begin
                out_valid_nxt = 1'b0;
                trans_raddr   = '0;
                state_nxt     = S_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      S_APP: begin
        trans_we        = 1'b1;
        trans_count_nxt = trans_count_r + TCW'(1);
        res_sec_nxt     = trans_wdata.loc;
        res_off_nxt     = type_rd_r.offset;
        res_dst_nxt     = type_rd_r.dst;
        res_abb_nxt     = type_rd_r.abbrev;
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_FIRST: begin
        if ($signed(cmd_r.time_value) < $signed(key)) begin
          ty_nxt    = '0;
          state_nxt = S_TYPE_RD;
        end else begin
          // The search runs over the whole list so that an unordered list
          // follows the same probe sequence as a plain binary search.
          lo_nxt    = '0;
          hi_nxt    = trans_count_r;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          trans_raddr = mid_sum[TAW:1];
          mid_nxt     = mid_sum[TAW:1];
          state_nxt   = S_SRCH_CMP;
        end else if (cmd_r.kind == K_UTC_Q || lo_r == trans_count_r) begin
          trans_raddr = lo_m1[TAW-1:0];
          state_nxt   = S_PICK;
        end else begin
          trans_raddr = lo_r[TAW-1:0];
          state_nxt   = S_LOC_I;
        end
      end
      S_SRCH_CMP: begin
        if ($signed(cmd_r.time_value) < $signed(key)) hi_nxt = TCW'(mid_r);
        else lo_nxt = TCW'(mid_r) + TCW'(1);
        state_nxt = S_SRCH;
      end
      S_PICK: begin
        ty_nxt    = trans_rd_r.ty;
        state_nxt = S_TYPE_RD;
      end
      S_LOC_I: begin
        utc_i_nxt   = trans_rd_r.utc;
        type_i_nxt  = trans_rd_r.ty;
        trans_raddr = lo_m1[TAW-1:0];
        state_nxt   = S_LOC_J;
      end
      S_LOC_J: begin
        utc_j_nxt  = trans_rd_r.utc;
        type_j_nxt = trans_rd_r.ty;
        type_raddr = trans_rd_r.ty[TYAW-1:0];
        state_nxt  = S_LOC_OFF1;
      end
      S_LOC_OFF1: begin
        // Local time of the instant just before transition i.
        prior = utc_i_r - TimeW'(1) + off64;
        if ($signed(prior) < $signed(cmd_r.time_value)) begin
          ty_nxt    = cmd_r.after_transition ? type_i_r : type_j_r;
          state_nxt = S_TYPE_RD;
        end else if (lo_r == TCW'(1)) begin
          ty_nxt    = type_j_r;
          state_nxt = S_TYPE_RD;
        end else begin
          trans_raddr = lo_m2[TAW-1:0];
          state_nxt   = S_LOC_JM1;
        end
      end
      S_LOC_JM1: begin
        ty_nxt     = trans_rd_r.ty;
        type_raddr = trans_rd_r.ty[TYAW-1:0];
        state_nxt  = S_LOC_OFF2;
      end
      S_LOC_OFF2: begin
        prior = utc_j_r - TimeW'(1) + off64;
        if (!($signed(prior) < $signed(cmd_r.time_value))) begin
          ty_nxt = cmd_r.after_transition ? type_j_r : ty_r;
        end else begin
          ty_nxt = type_j_r;
        end
        state_nxt = S_TYPE_RD;
      end
      S_TYPE_RD: begin
        state_nxt = S_TYPE_WAIT;
      end
      S_TYPE_WAIT: begin
        res_sec_nxt   = (cmd_r.kind == K_UTC_Q) ? cmd_r.time_value + off64
                                                 : cmd_r.time_value - off64;
        res_off_nxt   = type_rd_r.offset;
        res_dst_nxt   = type_rd_r.dst;
        res_abb_nxt   = type_rd_r.abbrev;
        res_st_nxt    = ST_OK;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      trans_count_r <= '0;
      type_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      trans_count_r <= trans_count_nxt;
      type_count_r  <= type_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    utc_i_r   <= utc_i_nxt;
    utc_j_r   <= utc_j_nxt;
    type_i_r  <= type_i_nxt;
    type_j_r  <= type_j_nxt;
    ty_r      <= ty_nxt;
    res_sec_r <= res_sec_nxt;
    res_off_r <= res_off_nxt;
    res_dst_r <= res_dst_nxt;
    res_abb_r <= res_abb_nxt;
    res_st_r  <= res_st_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_seconds = res_sec_r;
  assign out_ch.chosen_offset  = res_off_r;
  assign out_ch.chosen_dst     = res_dst_r;
  assign out_ch.chosen_abbrev  = res_abb_r;
  assign out_ch.status         = res_st_r;

  `TOL_ASSERT(a_busy_no_result, clk, rst_n, (state_r != S_IDLE) |-> !out_valid_r, "result pending while busy")
  `TOL_ASSERT(a_trans_bound, clk, rst_n, trans_count_r <= TCW'(MaxTransitions), "transition count overflow")
  `TOL_ASSERT(a_type_bound, clk, rst_n, type_count_r <= TYCW'(MaxTypes), "type count overflow")
  `TOL_ASSERT(a_search_window, clk, rst_n, (state_r == S_SRCH) |-> (lo_r <= hi_r && hi_r <= trans_count_r), "search window broken")
  `TOL_ASSERT_ALWAYS(a_pop_idle, clk, q_pop |-> (state_r == S_IDLE && q_head.valid), "pop outside idle")

endmodule

// ===== hdl/tz_transition_offset_lookup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tz_transition_offset_lookup_core
// Time-zone type and transition tables with UTC and local-time lookup.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per beat (clear, write type, append transition,
//   UTC query, local query); out_ch returns exactly one result beat for each.
//   A two-entry queue takes input beats while the engine works, so the sender
//   is stalled only when both entries are full. A beat is registered in the
//   queue before the engine takes it.
//   Clear, type write and rejected commands are answered from the idle
//   state, an append from S_APP, and a query with no transitions stored
//   after reading its type (S_TYPE_RD, S_TYPE_WAIT). Other queries run a
//   binary search of S steps (at most log2(N) + 1 for N stored transitions,
//   each a probe and a compare state, as the transition memory has one
//   registered read port), and a local query then reads the neighbors.
//   One command is processed at a time.
//   Reset clears the type and transition counts; the table memories are not
//   cleared and need no sweep. A stalled receiver holds the result in the
//   output register and the engine waits before starting the next command.
// ----------------------------------------------------------------------------
module tz_transition_offset_lookup_core import tol_pkg::*; #(
  parameter int MaxTransitions = DefMaxTransitions,
  parameter int MaxTypes       = DefMaxTypes
) (
  input  logic      clk,
  input  logic      rst_n,
  tol_in_if.sink    in_ch,
  tol_out_if.source out_ch
);

  q_head_t q_head;
  logic    q_pop;

  tol_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  tol_engine #(
    .MaxTransitions (MaxTransitions),
    .MaxTypes       (MaxTypes)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== test/tz_transition_offset_lookup_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tz_transition_offset_lookup_core_test
// Drives commands into the lookup core and checks every result beat against
// a predictor that keeps its own type and transition tables.
// ----------------------------------------------------------------------------
module tz_transition_offset_lookup_core_test;
  import tol_pkg::*;

  localparam int NTrans = 256;
  localparam int NTypes = 256;
  localparam int WatchLimit = 20000;
  // Opcodes that the core treats as no operation.
  localparam int OpUnused5 = 5;
  localparam int OpUnused7 = 7;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic [TyW-1:0] ty;
    logic signed [OffW-1:0] off;
    logic dst;
    logic [AbbW-1:0] abb;
    logic signed [TimeW-1:0] tv;
    logic aft;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [TimeW-1:0] secs;
    logic signed [OffW-1:0] off;
    logic dst;
    logic [AbbW-1:0] abb;
    logic [StW-1:0] st;
  } res_beat_t;

  // Directed rows; chk marks rows whose result is typed in.
  typedef struct packed {
    cmd_beat_t c;
    logic chk;
    res_beat_t r;
  } dir_row_t;

  logic clk;
  logic rst_n;
  tol_in_if in_ch ();
  tol_out_if out_ch ();

  tz_transition_offset_lookup_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Predictor state.
  logic signed [OffW-1:0] zone_off[NTypes];
  logic zone_dst[NTypes];
  logic [AbbW-1:0] zone_abb[NTypes];
  int zone_cnt;
  logic signed [TimeW-1:0] tr_utc[NTrans];
  logic signed [TimeW-1:0] tr_loc[NTrans];
  logic [TyW-1:0] tr_ty[NTrans];
  int tr_cnt;

  res_beat_t pending_results[$];
  int fails;
  int sent, got;
  int idle_pct, stall_pct;
  bit hold_off;
  int quiet;

  function automatic int first_above(bit use_loc, int n, logic signed [63:0] t);
    int lo, hi, mid;
    logic signed [63:0] k;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      k = use_loc ? tr_loc[mid] : tr_utc[mid];
      if (t < k) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic int zone_at_utc(logic signed [63:0] t);
    int i;
    if (tr_cnt == 0 || t < tr_utc[0]) return 0;
    i = first_above(1'b0, tr_cnt, t);
    return tr_ty[i-1];
  endfunction

  function automatic int zone_at_local(logic signed [63:0] t, bit aft);
    int i, j, pt;
    logic signed [63:0] prior;
    if (tr_cnt == 0 || t < tr_loc[0]) return 0;
    i = first_above(1'b1, tr_cnt, t);
    if (i == tr_cnt) return tr_ty[tr_cnt-1];
    pt = tr_ty[i-1];
    prior = tr_utc[i] - 64'sd1 + 64'(zone_off[pt]);
    if (prior < t) return aft ? tr_ty[i] : pt;
    j = i - 1;
    if (j != 0) begin
      pt = tr_ty[j-1];
      prior = tr_utc[j] - 64'sd1 + 64'(zone_off[pt]);
    end
    if (!(prior < t)) return aft ? tr_ty[j] : pt;
    return tr_ty[j];
  endfunction

  function automatic res_beat_t convert_cmd(cmd_beat_t c);
    res_beat_t r;
    int z;
    r = '0;
    case (c.op)
      OP_CLEAR: begin
        zone_cnt = 0;
        tr_cnt = 0;
      end
      OP_WR_TYPE: begin
        zone_off[c.ty] = c.off;
        zone_dst[c.ty] = c.dst;
        zone_abb[c.ty] = c.abb;
        if (zone_cnt < c.ty + 1) zone_cnt = c.ty + 1;
        r.off = c.off;
        r.dst = c.dst;
        r.abb = c.abb;
      end
      OP_APPEND: begin
        if (c.ty >= zone_cnt) r.st = ST_BAD_TYPE;
        else if (tr_cnt >= NTrans) r.st = ST_FULL;
        else begin
          tr_utc[tr_cnt] = c.tv;
          tr_loc[tr_cnt] = c.tv + 64'(zone_off[c.ty]);
          tr_ty[tr_cnt] = c.ty;
          r.secs = tr_loc[tr_cnt];
          tr_cnt++;
          r.off = zone_off[c.ty];
          r.dst = zone_dst[c.ty];
          r.abb = zone_abb[c.ty];
        end
      end
      OP_UTC_Q, OP_LOC_Q: begin
        if (zone_cnt == 0) r.st = ST_NO_TYPES;
        else begin
          if (c.op == OP_UTC_Q) begin
            z = zone_at_utc(c.tv);
            r.secs = c.tv + 64'(zone_off[z]);
          end else begin
            z = zone_at_local(c.tv, c.aft);
            r.secs = c.tv - 64'(zone_off[z]);
          end
          r.off = zone_off[z];
          r.dst = zone_dst[z];
          r.abb = zone_abb[z];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: ready with random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    res_beat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.result_seconds !== e.secs) begin
          $error("result_seconds exp %0d got %0d", e.secs, out_ch.result_seconds);
          fails++;
        end
        if (out_ch.chosen_offset !== e.off) begin
          $error("chosen_offset exp %0d got %0d", e.off, out_ch.chosen_offset);
          fails++;
        end
        if (out_ch.chosen_dst !== e.dst) begin
          $error("chosen_dst exp %0d got %0d", e.dst, out_ch.chosen_dst);
          fails++;
        end
        if (out_ch.chosen_abbrev !== e.abb) begin
          $error("chosen_abbrev exp %0d got %0d", e.abb, out_ch.chosen_abbrev);
          fails++;
        end
        if (out_ch.status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_ch.status);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("FAIL tz_transition_offset_lookup_core");
      $finish;
    end
  end

  task automatic send_beat(cmd_beat_t c, bit chk, res_beat_t want);
    res_beat_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= c.op;
    in_ch.type_index <= c.ty;
    in_ch.offset_seconds <= c.off;
    in_ch.dst_flag <= c.dst;
    in_ch.abbrev_index <= c.abb;
    in_ch.time_value <= c.tv;
    in_ch.after_transition <= c.aft;
    do @(posedge clk); while (!in_ch.ready);
    r = convert_cmd(c);
    if (chk && r !== want) begin
      $error("directed row disagrees with predictor");
      fails++;
    end
    pending_results.insert(pending_results.size(), r);
    sent++;
  endtask

  function automatic cmd_beat_t mk(int op, int ty, int off, logic [63:0] tv, int aft);
    cmd_beat_t c;
    c.op = OpW'(op);
    c.ty = TyW'(ty);
    c.off = OffW'(off);
    c.dst = 1'($urandom_range(1));
    c.abb = AbbW'($urandom);
    c.tv = tv;
    c.aft = 1'(aft);
    return c;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // A small zone with a handful of ascending transitions, then queries
  // mostly near the transitions so gaps and overlaps are hit.
  task automatic zone_scenario();
    int nty, ntr, k, q, pick;
    logic signed [63:0] t;
    cmd_beat_t c;
    send_beat(mk(OP_CLEAR, 0, 0, rnd64(), 0), 0, '0);
    nty = $urandom_range(4, 1);
    for (k = 0; k < nty; k++) begin
      c = mk(OP_WR_TYPE, k, int'($urandom_range(14400)) - 7200, 0, 0);
      if ($urandom_range(9) == 0) c.off = OffW'(int'($urandom_range(187200)) - 93600);
      send_beat(c, 0, '0);
    end
    ntr = $urandom_range(12);
    t = $signed(64'(int'($urandom_range(100000)))) - 64'sd50000;
    for (k = 0; k < ntr; k++) begin
      t = t + 64'($urandom_range(20000, 1));
      send_beat(mk(OP_APPEND, $urandom_range(nty), 0, t, 0), 0, '0);
    end
    for (q = 0; q < 10; q++) begin
      pick = (tr_cnt > 0) ? $urandom_range(tr_cnt - 1) : 0;
      t = (tr_cnt > 0 ? tr_utc[pick] : 64'sd0) + 64'(int'($urandom_range(16000)) - 8000);
      if ($urandom_range(9) == 0) t = rnd64();
      send_beat(mk($urandom_range(1) ? OP_UTC_Q : OP_LOC_Q, 0, 0, t, $urandom_range(1)),
                0, '0);
    end
  endtask

  task automatic random_noise();
    cmd_beat_t c;
    c = mk($urandom_range(7), $urandom_range(255), int'($urandom_range(187200)) - 93600,
           rnd64(), $urandom_range(1));
    // Keep type writes at or below the next free slot, so no undefined entry is read.
    if (c.op == OP_WR_TYPE && c.ty > zone_cnt) c.ty = TyW'(zone_cnt);
    if (c.op == OP_CLEAR && $urandom_range(3) != 0) c.op = OP_UTC_Q;
    send_beat(c, 0, '0);
  endtask

  dir_row_t dir_rows[$];
  res_beat_t z;
  cmd_beat_t c;
  int k, ph, wait_cnt;

  function automatic void add_row(dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.type_index = '0;
    in_ch.offset_seconds = '0;
    in_ch.dst_flag = 1'b0;
    in_ch.abbrev_index = '0;
    in_ch.time_value = '0;
    in_ch.after_transition = 1'b0;
    hold_off = 0;
    idle_pct = 0;
    stall_pct = 0;
    fails = 0;
    sent = 0;
    got = 0;
    zone_cnt = 0;
    tr_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: errors from empty tables, extremes, then gaps/overlaps.
    z = '0;
    add_row('{mk(OP_UTC_Q, 0, 0, 64'd5, 0), 1, '{0, 0, 0, 0, ST_NO_TYPES}});
    add_row('{mk(OP_LOC_Q, 0, 0, 64'd5, 1), 1, '{0, 0, 0, 0, ST_NO_TYPES}});
    add_row('{mk(OP_APPEND, 0, 0, 64'd0, 0), 1, '{0, 0, 0, 0, ST_BAD_TYPE}});
    add_row('{mk(OpUnused5, 0, 0, 64'd0, 0), 1, z});
    add_row('{mk(OpUnused7, 255, 0, '1, 1), 1, z});
    c = mk(OP_WR_TYPE, 0, 0, 0, 0);
    c.dst = 0;
    c.abb = 0;
    add_row('{c, 1, '{0, 0, 0, 0, ST_OK}});
    c = mk(OP_WR_TYPE, 1, 3600, 0, 0);
    c.dst = 1;
    c.abb = 255;
    add_row('{c, 1, '{0, 3600, 1, 255, ST_OK}});
    c = mk(OP_WR_TYPE, 255, -93600, 0, 0);
    c.dst = 1;
    c.abb = 8'hA5;
    add_row('{c, 1, '{0, -93600, 1, 8'hA5, ST_OK}});
    c = mk(OP_WR_TYPE, 254, 93600, 0, 0);
    c.dst = 0;
    c.abb = 8'h5A;
    add_row('{c, 1, '{0, 93600, 0, 8'h5A, ST_OK}});
    add_row('{mk(OP_UTC_Q, 0, 0, 64'h8000000000000000, 0), 0, z});
    add_row('{mk(OP_APPEND, 1, 0, 64'sd1000, 0), 0, z});
    add_row('{mk(OP_APPEND, 0, 0, 64'sd9000, 0), 0, z});
    add_row('{mk(OP_APPEND, 254, 0, 64'h7FFFFFFFFFFFFFFF, 0), 0, z});
    add_row('{mk(OP_UTC_Q, 0, 0, 64'sd999, 0), 0, z});
    add_row('{mk(OP_UTC_Q, 0, 0, 64'sd1000, 0), 0, z});
    add_row('{mk(OP_LOC_Q, 0, 0, 64'sd3000, 0), 0, z});
    add_row('{mk(OP_LOC_Q, 0, 0, 64'sd3000, 1), 0, z});
    add_row('{mk(OP_LOC_Q, 0, 0, 64'sd9500, 0), 0, z});
    add_row('{mk(OP_LOC_Q, 0, 0, 64'sd9500, 1), 0, z});
    add_row('{mk(OP_LOC_Q, 0, 0, 64'sd500, 1), 0, z});
    add_row('{mk(OP_UTC_Q, 0, 0, 64'h7FFFFFFFFFFFFFFF, 1), 0, z});
    add_row('{mk(OP_APPEND, 1, 0, 64'sd5, 0), 0, z});
    add_row('{mk(OP_APPEND, 0, 0, -64'sd5, 0), 0, z});
    add_row('{mk(OP_LOC_Q, 0, 0, '1, 1), 0, z});
    add_row('{mk(OP_CLEAR, 0, 0, 0, 0), 1, z});
    foreach (dir_rows[i]) send_beat(dir_rows[i].c, dir_rows[i].chk, dir_rows[i].r);

    // Fill the transition list to its limit and beyond to see the full status.
    c = mk(OP_WR_TYPE, 0, 0, 0, 0);
    send_beat(c, 0, '0);
    for (k = 0; k < NTrans + 2; k++)
      send_beat(mk(OP_APPEND, 0, 0, 64'(k * 10), 0), 0, '0);
    for (k = 0; k < 8; k++)
      send_beat(mk(OP_LOC_Q, 0, 0, 64'($urandom_range(2600)), $urandom_range(1)), 0, '0);

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (k = 0; k < 6; k++) send_beat(mk(OP_UTC_Q, 0, 0, rnd64(), 0), 0, '0);
    join

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        3: begin idle_pct = 20; stall_pct = 20; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (k = 0; k < 12; k++) zone_scenario();
      for (k = 0; k < 60; k++) random_noise();
    end
    in_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (40) @(posedge clk);
    $display("Sent %0d commands (clears, type writes, appends, both query kinds),", sent);
    $display("checked %0d results under five idle and stall mixes.", got);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("PASS tz_transition_offset_lookup_core");
    end else begin
      $display("FAIL tz_transition_offset_lookup_core");
    end
    $finish;
  end

endmodule
